// ----- rtl/command_script_deframer_assert.svh -----
// Assertion macros shared by the deframer checker.
// No dependencies; clock and reset are taken from the including scope.
`ifndef COMMAND_SCRIPT_DEFRAMER_ASSERT_SVH
`define COMMAND_SCRIPT_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("command_script_deframer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("command_script_deframer: next-cycle check failed");

`endif

// ----- rtl/csd_pkg.sv -----
// Shared types and constants for the command script deframer.
// No dependencies.
package csd_pkg;

   localparam logic [7:0] START_BYTE = 8'h7e;
   localparam logic [7:0] TERM_ID    = 8'hff;
   localparam logic [7:0] TERM_MID   = 8'h01;
   localparam logic [7:0] TERM_LAST  = 8'hfe;

   typedef enum logic [3:0] {
      EV_HDR_BYTE  = 4'd0,
      EV_HDR_DONE  = 4'd1,
      EV_CMD_BYTE  = 4'd2,
      EV_COMMIT    = 4'd3,
      EV_DELAY_LO  = 4'd4,
      EV_DELAY_RDY = 4'd5,
      EV_END       = 4'd6,
      EV_IGNORED   = 4'd7,
      EV_NO_START  = 4'd8,
      EV_BAD_SUM   = 4'd9,
      EV_EARLY_END = 4'd10,
      EV_NO_END    = 4'd11,
      EV_BAD_END   = 4'd12
   } evt_type;

   typedef struct packed {
      evt_type      event_res;
      logic         forward;
      logic [7:0]   data_byte;
      logic [7:0]   command_id;
      logic [7:0]   command_number;
      logic [15:0]  wait_seconds;
      logic [31:0]  begin_time;
      logic [15:0]  repeat_seconds;
      logic [7:0]   total_commands;
   } res_type;

endpackage

// ----- rtl/command_script_deframer.sv -----
// Top level of the command script deframer: handshake and result register.
// Depends on csd_pkg and csd_parser.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  script_byte, script_start
//   rsp       out        rsp_valid/rsp_ready  event_res .. total_commands
//
// One script byte per cycle while req_ready is high; each byte's result shows the cycle after.
// The rate is set by the parser state update, registered on each transfer, feeding the result register.
// Reset clears the parser to idle and empties the result register.
// While a result waits on rsp_ready, a new byte is taken only in the cycle
// that the waiting result is transferred out.
module command_script_deframer
   import csd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_script_byte,
   input  logic        req_script_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_res,
   output logic        rsp_forward,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_command_id,
   output logic [7:0]  rsp_command_number,
   output logic [15:0] rsp_wait_seconds,
   output logic [31:0] rsp_begin_time,
   output logic [15:0] rsp_repeat_seconds,
   output logic [7:0]  rsp_total_commands
);

   res_type res;
   res_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   csd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .script_byte  (req_script_byte),
      .script_start (req_script_start),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_forward        = rsp_ff.forward;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_command_id     = rsp_ff.command_id;
   assign rsp_command_number = rsp_ff.command_number;
   assign rsp_wait_seconds   = rsp_ff.wait_seconds;
   assign rsp_begin_time     = rsp_ff.begin_time;
   assign rsp_repeat_seconds = rsp_ff.repeat_seconds;
   assign rsp_total_commands = rsp_ff.total_commands;

endmodule

// ----- rtl/csd_parser.sv -----
// Script parser: header capture, command framing, checksum and terminator checks.
// Depends on csd_pkg. Produces the result of the byte being transferred this cycle.
module csd_parser
   import csd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] script_byte,
   input  logic       script_start,
   output res_type    res
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_HDR   = 4'd1,
      PH_START = 4'd2,
      PH_ID    = 4'd3,
      PH_LEN   = 4'd4,
      PH_DATA  = 4'd5,
      PH_SUM   = 4'd6,
      PH_DLO   = 4'd7,
      PH_DHI   = 4'd8,
      PH_T1    = 4'd9,
      PH_T2    = 4'd10
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [2:0]  hdr_pos_ff, hdr_pos_in, hdr_pos_cur;
   logic [31:0] start_time_ff, start_time_in, start_time_cur;
   logic [15:0] repeat_ff, repeat_in, repeat_cur;
   logic [7:0]  count_ff, count_in, count_cur;
   logic [7:0]  index_ff, index_in, index_cur;
   logic [7:0]  left_ff, left_in, left_cur;
   logic [7:0]  xor_ff, xor_in, xor_cur;
   logic [7:0]  id_ff, id_in, id_cur;
   logic [7:0]  dlo_ff, dlo_in, dlo_cur;
   logic        last_slot;
   evt_type     ev;
   logic        fwd;
   logic [15:0] wait_val;

   // A script start restarts the parser and takes this byte as header byte 0.
   always_comb begin
      phase_cur      = script_start ? PH_HDR : phase_ff;
      hdr_pos_cur    = script_start ? 3'd0  : hdr_pos_ff;
      start_time_cur = script_start ? 32'd0 : start_time_ff;
      repeat_cur     = script_start ? 16'd0 : repeat_ff;
      count_cur      = script_start ? 8'd0  : count_ff;
      index_cur      = script_start ? 8'd0  : index_ff;
      left_cur       = script_start ? 8'd0  : left_ff;
      xor_cur        = script_start ? 8'd0  : xor_ff;
      id_cur         = script_start ? 8'd0  : id_ff;
      dlo_cur        = script_start ? 8'd0  : dlo_ff;
   end

   assign last_slot = (index_cur == (count_cur - 8'd1));

   always_comb begin
      phase_in      = phase_cur;
      hdr_pos_in    = hdr_pos_cur;
      start_time_in = start_time_cur;
      repeat_in     = repeat_cur;
      count_in      = count_cur;
      index_in      = index_cur;
      left_in       = left_cur;
      xor_in        = xor_cur;
      id_in         = id_cur;
      dlo_in        = dlo_cur;
      ev            = EV_IGNORED;
      fwd           = 1'b0;
      wait_val      = 16'd0;

      unique case (phase_cur)
         PH_HDR: begin
            case (hdr_pos_cur)
               3'd1: start_time_in[7:0]   = start_time_cur[7:0]   | script_byte;
               3'd2: start_time_in[15:8]  = start_time_cur[15:8]  | script_byte;
               3'd3: start_time_in[23:16] = start_time_cur[23:16] | script_byte;
               3'd4: start_time_in[31:24] = start_time_cur[31:24] | script_byte;
               3'd5: repeat_in[7:0]       = script_byte;
               3'd6: repeat_in[15:8]      = script_byte;
               default: ;
            endcase
            if (hdr_pos_cur == 3'd7) begin
               count_in   = script_byte;
               index_in   = 8'd0;
               hdr_pos_in = 3'd0;
               ev         = EV_HDR_DONE;
               phase_in   = (script_byte == 8'd0) ? PH_IDLE : PH_START;
            end else begin
               hdr_pos_in = hdr_pos_cur + 3'd1;
               ev         = EV_HDR_BYTE;
            end
         end
         PH_START: begin
            if (script_byte == START_BYTE) begin
               xor_in   = 8'd0;
               ev       = EV_CMD_BYTE;
               fwd      = 1'b1;
               phase_in = PH_ID;
            end else begin
               ev       = EV_NO_START;
               phase_in = PH_IDLE;
            end
         end
         PH_ID: begin
            id_in = script_byte;
            if (script_byte == TERM_ID) begin
               ev       = EV_CMD_BYTE;
               phase_in = PH_T1;
            end else if (last_slot) begin
               ev       = EV_NO_END;
               phase_in = PH_IDLE;
            end else begin
               xor_in   = script_byte;
               ev       = EV_CMD_BYTE;
               fwd      = 1'b1;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            xor_in   = xor_cur ^ script_byte;
            left_in  = script_byte;
            ev       = EV_CMD_BYTE;
            fwd      = 1'b1;
            phase_in = (script_byte == 8'd0) ? PH_SUM : PH_DATA;
         end
         PH_DATA: begin
            xor_in  = xor_cur ^ script_byte;
            left_in = left_cur - 8'd1;
            ev      = EV_CMD_BYTE;
            fwd     = 1'b1;
            if (left_cur == 8'd1) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            if (script_byte == xor_cur) begin
               ev       = EV_COMMIT;
               fwd      = 1'b1;
               phase_in = PH_DLO;
            end else begin
               ev       = EV_BAD_SUM;
               phase_in = PH_IDLE;
            end
         end
         PH_DLO: begin
            dlo_in   = script_byte;
            ev       = EV_DELAY_LO;
            phase_in = PH_DHI;
         end
         PH_DHI: begin
            wait_val = {script_byte, dlo_cur};
            ev       = EV_DELAY_RDY;
            index_in = index_cur + 8'd1;
            phase_in = PH_START;
         end
         PH_T1: begin
            if (script_byte == TERM_MID) begin
               ev       = EV_CMD_BYTE;
               phase_in = PH_T2;
            end else begin
               ev       = EV_BAD_END;
               phase_in = PH_IDLE;
            end
         end
         PH_T2: begin
            if (script_byte != TERM_LAST) begin
               ev = EV_BAD_END;
            end else if (last_slot) begin
               ev = EV_END;
            end else begin
               ev = EV_EARLY_END;
            end
            phase_in = PH_IDLE;
         end
         default: begin
            ev       = EV_IGNORED;
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      res.event_res      = ev;
      res.forward        = fwd;
      res.data_byte      = fwd ? script_byte : 8'd0;
      res.command_id     = id_in;
      res.command_number = index_in;
      res.wait_seconds   = wait_val;
      res.begin_time     = start_time_in;
      res.repeat_seconds = repeat_in;
      res.total_commands = count_in;
   end

   // Advance only on a transfer; otherwise hold.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_pos_ff    <= 3'd0;
         start_time_ff <= 32'd0;
         repeat_ff     <= 16'd0;
         count_ff      <= 8'd0;
         index_ff      <= 8'd0;
         left_ff       <= 8'd0;
         xor_ff        <= 8'd0;
         id_ff         <= 8'd0;
         dlo_ff        <= 8'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         start_time_ff <= start_time_in;
         repeat_ff     <= repeat_in;
         count_ff      <= count_in;
         index_ff      <= index_in;
         left_ff       <= left_in;
         xor_ff        <= xor_in;
         id_ff         <= id_in;
         dlo_ff        <= dlo_in;
      end
   end

endmodule

// ----- rtl/csd_checker.sv -----
// Port-level checks for the command script deframer, bound to the top level.
// Depends on csd_pkg and command_script_deframer_assert.svh.
`include "command_script_deframer_assert.svh"

module csd_checker
   import csd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_event_res,
   input logic        rsp_forward,
   input logic [7:0]  rsp_data_byte,
   input logic [15:0] rsp_wait_seconds
);

   logic fwd_event_ok;
   logic no_delay_event;

   assign fwd_event_ok   = (rsp_event_res == EV_CMD_BYTE) || (rsp_event_res == EV_COMMIT);
   assign no_delay_event = (rsp_event_res != EV_DELAY_RDY);

   `CSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res))
   `CSD_ASSERT_NOW(a_no_fwd_zero, rsp_valid && !rsp_forward, rsp_data_byte == 8'd0)
   `CSD_ASSERT_NOW(a_fwd_event, rsp_valid && rsp_forward, fwd_event_ok)
   `CSD_ASSERT_NOW(a_wait_only_ready, rsp_valid && no_delay_event, rsp_wait_seconds == 16'd0)

endmodule

bind command_script_deframer csd_checker u_checker (.*);
